// File: hw/rtl/gdfs_pkg.sv
package gdfs_pkg;

  localparam int VTX_W  = 5;
  localparam int VCNT_W = 6;
  localparam int LIM_W  = 7;
  localparam int OP_W   = 2;
  localparam int STS_W  = 3;

  localparam int DEF_MAX_VERTICES = 32;
  localparam int DEF_MAX_EDGES    = 256;

  localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(32);

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STS_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STS_W-1:0] ST_REJECTED = 3'd1;
  localparam logic [STS_W-1:0] ST_PATH     = 3'd2;
  localparam logic [STS_W-1:0] ST_NOPATH   = 3'd3;
  localparam logic [STS_W-1:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VTX_W-1:0] from_vertex;
    logic [VTX_W-1:0] to_vertex;
  } in_item_t;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [VTX_W-1:0] vertex;
    logic             last;
  } out_item_t;

  typedef enum logic [1:0] {
    OK_NONE,
    OK_RESP,
    OK_TOP,
    OK_STACK
  } out_kind_t;

  typedef struct packed {
    logic             clear;
    logic             add;
    logic             q_init;
    logic             scan;
    logic             pop;
    logic             pop_ld;
    logic             emit_rd;
    out_kind_t        out_kind;
    logic [STS_W-1:0] resp;
  } cmd_t;

  localparam cmd_t CMD_NONE = cmd_t'(0);

  typedef struct packed {
    logic add_ok;
    logic range_ok;
    logic start_is_target;
    logic hit_target;
    logic exhausted;
    logic depth_one;
    logic depth_two;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/graph_dfs_path_finder.sv
// Directed-graph path finder with an edge table and depth-first search.
// Input channel in_valid/in_stall/in_data: op 0 clears the table, op 1
// appends edge from_vertex->to_vertex, op 2 searches from from_vertex to
// to_vertex. Result channel out_valid/out_stall/out_data: one status per
// clear, add or unused op; a query returns the path from target to start,
// one vertex per transfer with last on the start, or a single no-path result.
// cfg_valid/cfg_ready/cfg_data writes vertex_count; cfg_ready is always high.
// A clear or unused-op result goes from the command register into the output
// register once that is free; an add first writes the table in S_ADD.
// A query checks its range in S_QINIT, then per visited vertex scans the edge
// table newest entry first through its single read port (S_SCAN), pushes on
// a hit and pops through S_POP and S_POPLD; the path then leaves through
// S_EMIT_RD and S_EMIT_WR, one vertex per pass.
// One item is worked on at a time; in_stall is high from acceptance until
// the last result is in the output register, which frees the input while
// that result still waits. A stalled receiver holds the output register and
// pauses the block. Reset clears the edge table fill, the visited marks and
// the output register, and sets vertex_count to 32; no clearing pass runs.
module graph_dfs_path_finder import gdfs_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [VCNT_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic accept;

  assign accept = in_valid && !in_stall;

  gdfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_op    (in_data.op),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  gdfs_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/gdfs_ctrl.sv
module gdfs_ctrl import gdfs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [OP_W-1:0] in_op,
  input  sts_t            sts,
  output cmd_t            cmd,
  output logic            in_stall
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_RESP,
    S_QINIT,
    S_SCAN,
    S_POP,
    S_POPLD,
    S_FOUND,
    S_EMIT_RD,
    S_EMIT_WR
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;
  logic   stall_r, stall_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    stall_nxt = stall_r;
    unique case (state_r)
      S_IDLE: begin
        cmd_nxt = CMD_NONE;
        if (accept) begin
          stall_nxt = 1'b1;
          unique case (in_op)
            OP_CLEAR: begin
              state_nxt        = S_RESP;
              cmd_nxt.clear    = 1'b1;
              cmd_nxt.out_kind = OK_RESP;
              cmd_nxt.resp     = ST_CLEARED;
            end
            OP_ADD: begin
              state_nxt   = S_ADD;
              cmd_nxt.add = 1'b1;
            end
            OP_QUERY: begin
              state_nxt      = S_QINIT;
              cmd_nxt.q_init = 1'b1;
            end
            default: begin
              state_nxt        = S_RESP;
              cmd_nxt.out_kind = OK_RESP;
              cmd_nxt.resp     = ST_REJECTED;
            end
          endcase
        end
      end
      S_ADD: begin
        state_nxt        = S_RESP;
        cmd_nxt          = CMD_NONE;
        cmd_nxt.out_kind = OK_RESP;
        cmd_nxt.resp     = sts.add_ok ? ST_ADDED : ST_REJECTED;
      end
      S_RESP: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
          cmd_nxt   = CMD_NONE;
          stall_nxt = 1'b0;
        end
      end
      S_QINIT: begin
        cmd_nxt = CMD_NONE;
        priority if (!sts.range_ok) begin
          state_nxt        = S_RESP;
          cmd_nxt.out_kind = OK_RESP;
          cmd_nxt.resp     = ST_NOPATH;
        end else if (sts.start_is_target) begin
          state_nxt        = S_FOUND;
          cmd_nxt.out_kind = OK_TOP;
        end else begin
          state_nxt    = S_SCAN;
          cmd_nxt.scan = 1'b1;
        end
      end
      S_SCAN: begin
        priority if (sts.hit_target) begin
          state_nxt        = S_FOUND;
          cmd_nxt          = CMD_NONE;
          cmd_nxt.out_kind = OK_TOP;
        end else if (sts.exhausted) begin
          state_nxt   = S_POP;
          cmd_nxt     = CMD_NONE;
          cmd_nxt.pop = 1'b1;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_POP: begin
        cmd_nxt = CMD_NONE;
        if (sts.depth_one) begin
          state_nxt        = S_RESP;
          cmd_nxt.out_kind = OK_RESP;
          cmd_nxt.resp     = ST_NOPATH;
        end else begin
          state_nxt      = S_POPLD;
          cmd_nxt.pop_ld = 1'b1;
        end
      end
      S_POPLD: begin
        state_nxt    = S_SCAN;
        cmd_nxt      = CMD_NONE;
        cmd_nxt.scan = 1'b1;
      end
      S_FOUND: begin
        if (sts.out_free) begin
          cmd_nxt = CMD_NONE;
          if (sts.depth_one) begin
            state_nxt = S_IDLE;
            stall_nxt = 1'b0;
          end else begin
            state_nxt       = S_EMIT_RD;
            cmd_nxt.emit_rd = 1'b1;
          end
        end
      end
      S_EMIT_RD: begin
        state_nxt        = S_EMIT_WR;
        cmd_nxt          = CMD_NONE;
        cmd_nxt.out_kind = OK_STACK;
      end
      S_EMIT_WR: begin
        if (sts.out_free) begin
          cmd_nxt = CMD_NONE;
          if (sts.depth_two) begin
            state_nxt = S_IDLE;
            stall_nxt = 1'b0;
          end else begin
            state_nxt       = S_EMIT_RD;
            cmd_nxt.emit_rd = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cmd_nxt   = CMD_NONE;
        stall_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r   <= CMD_NONE;
      stall_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      stall_r <= stall_nxt;
    end
  end

  assign cmd      = cmd_r;
  assign in_stall = stall_r;

  a_idle_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !stall_r)
    else $error("stall high while idle");

  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("transfer accepted but controller stayed idle");

  a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.hit_target) |=> (state_r == S_FOUND))
    else $error("target reached but no path emission");

endmodule

// File: hw/rtl/gdfs_dp.sv
module gdfs_dp import gdfs_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  in_item_t          in_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [VCNT_W-1:0] cfg_data,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  localparam int EAW = $clog2(MAX_EDGES);
  localparam int EPW = $clog2(MAX_EDGES + 1);
  localparam int IW  = $clog2(MAX_VERTICES);
  localparam int DW  = $clog2(MAX_VERTICES + 1);
  localparam int FW  = VTX_W + EPW;

  logic [VCNT_W-1:0]    vcount_r;
  logic [LIM_W-1:0]     lim;
  in_item_t             item_r;
  logic [EPW-1:0]       edge_total_r;
  logic [EPW-1:0]       iss_pos_r;
  logic [EAW-1:0]       rd_idx_r;
  logic                 rd_v_r;
  logic [VTX_W-1:0]     cur_vtx_r;
  logic [DW-1:0]        depth_r;
  logic [MAX_VERTICES-1:0] visited_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;
  out_item_t            out_nxt;

  logic [2*VTX_W-1:0]   edge_mem [MAX_EDGES];
  logic [2*VTX_W-1:0]   edge_q;
  logic [FW-1:0]        stack_mem [MAX_VERTICES];
  logic [FW-1:0]        stack_q;

  logic [VTX_W-1:0]     e_src, e_dst;
  logic                 a_ok, b_ok, add_ok;
  logic                 hit, edge_rd, stk_rd, out_free, out_load;
  logic                 depth_one, depth_two;
  logic [IW-1:0]        stk_raddr;

  assign cfg_ready = 1'b1;

  assign lim = (LIM_W'(vcount_r) < LIM_W'(MAX_VERTICES)) ? LIM_W'(vcount_r)
                                                         : LIM_W'(MAX_VERTICES);
  assign a_ok   = LIM_W'(item_r.from_vertex) < lim;
  assign b_ok   = LIM_W'(item_r.to_vertex) < lim;
  assign add_ok = (edge_total_r < EPW'(MAX_EDGES)) && a_ok && b_ok;

  assign e_src = edge_q[2*VTX_W-1:VTX_W];
  assign e_dst = edge_q[VTX_W-1:0];

  assign hit = cmd.scan && rd_v_r && (e_src == cur_vtx_r) &&
               (LIM_W'(e_dst) < lim) && !visited_r[IW'(e_dst)];
  assign edge_rd = cmd.scan && !hit && (iss_pos_r != '0);

  assign depth_one = depth_r == DW'(1);
  assign depth_two = depth_r == DW'(2);
  assign stk_rd    = (cmd.pop && !depth_one) || cmd.emit_rd;
  assign stk_raddr = IW'(depth_r - DW'(2));

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (cmd.out_kind != OK_NONE) && out_free;

  always_comb begin
    out_nxt = '0;
    unique case (cmd.out_kind)
      OK_NONE: out_nxt = '0;
      OK_RESP: begin
        out_nxt.status = cmd.resp;
        out_nxt.last   = 1'b1;
      end
      OK_TOP: begin
        out_nxt.status = ST_PATH;
        out_nxt.vertex = cur_vtx_r;
        out_nxt.last   = depth_one;
      end
      OK_STACK: begin
        out_nxt.status = ST_PATH;
        out_nxt.vertex = stack_q[FW-1:EPW];
        out_nxt.last   = depth_two;
      end
    endcase
  end

  always_comb begin
    sts.add_ok          = add_ok;
    sts.range_ok        = a_ok && b_ok;
    sts.start_is_target = item_r.from_vertex == item_r.to_vertex;
    sts.hit_target      = hit && (e_dst == item_r.to_vertex);
    sts.exhausted       = cmd.scan && !rd_v_r && (iss_pos_r == '0);
    sts.depth_one       = depth_one;
    sts.depth_two       = depth_two;
    sts.out_free        = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.add && add_ok) begin
      edge_mem[EAW'(edge_total_r)] <= {item_r.from_vertex, item_r.to_vertex};
    end
    if (edge_rd) begin
      edge_q <= edge_mem[EAW'(iss_pos_r - EPW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      stack_mem[IW'(depth_r - DW'(1))] <= {cur_vtx_r, EPW'(rd_idx_r)};
    end
    if (stk_rd) begin
      stack_q <= stack_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r     <= VCNT_RESET;
      edge_total_r <= '0;
      rd_v_r       <= 1'b0;
      depth_r      <= '0;
      visited_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        vcount_r <= cfg_data;
      end
      if (cmd.clear) begin
        edge_total_r <= '0;
      end else if (cmd.add && add_ok) begin
        edge_total_r <= edge_total_r + EPW'(1);
      end
      if (cmd.q_init && a_ok && b_ok) begin
        visited_r <= MAX_VERTICES'(1) << item_r.from_vertex;
        depth_r   <= DW'(1);
        rd_v_r    <= 1'b0;
      end
      if (hit) begin
        visited_r[IW'(e_dst)] <= 1'b1;
        depth_r               <= depth_r + DW'(1);
      end
      if (cmd.scan) begin
        rd_v_r <= edge_rd;
      end
      if ((cmd.pop && !depth_one) || (out_load && cmd.out_kind == OK_STACK)) begin
        depth_r <= depth_r - DW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (cmd.q_init) begin
      cur_vtx_r <= item_r.from_vertex;
      iss_pos_r <= edge_total_r;
    end
    if (hit) begin
      cur_vtx_r <= e_dst;
      iss_pos_r <= edge_total_r;
    end else if (edge_rd) begin
      iss_pos_r <= iss_pos_r - EPW'(1);
      rd_idx_r  <= EAW'(iss_pos_r - EPW'(1));
    end
    if (cmd.pop_ld) begin
      cur_vtx_r <= stack_q[FW-1:EPW];
      iss_pos_r <= stack_q[EPW-1:0];
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> (depth_r < DW'(MAX_VERTICES)))
    else $error("search stack overflow");

  a_read_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (EPW'(rd_idx_r) < edge_total_r))
    else $error("edge read beyond table fill");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result load lost");

endmodule

// File: bench/tb_graph_dfs_path_finder.sv
`timescale 1ns / 100ps

module tb_graph_dfs_path_finder;
  import gdfs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int TABLE_DEPTH = DEF_MAX_EDGES;
  localparam int VTX_SLOTS = DEF_MAX_VERTICES;
  localparam int QUIET_LIMIT = 100_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [VCNT_W-1:0] cfg_data = '0;

  graph_dfs_path_finder uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_item_t graph_cmds[$];
  out_item_t graph_replies[$];
  int cmds_queued = 0;
  int cmds_taken = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit failed = 1'b0;
  bit in_took = 1'b0;
  bit cfg_took = 1'b0;

  // shadow of the block's graph state
  logic [VTX_W-1:0] edge_from[TABLE_DEPTH];
  logic [VTX_W-1:0] edge_to[TABLE_DEPTH];
  int edge_fill = 0;
  logic [VCNT_W-1:0] vcount_now = VCNT_RESET;

  function automatic int active_limit();
    return (vcount_now < VTX_SLOTS) ? int'(vcount_now) : VTX_SLOTS;
  endfunction

  function automatic void note_reply(logic [STS_W-1:0] status, logic [VTX_W-1:0] vtx,
                                     logic last);
    out_item_t r;
    r.status = status;
    r.vertex = vtx;
    r.last = last;
    graph_replies.push_back(r);
  endfunction

  // depth-first search, newest edge first, path reported target to start
  function automatic void walk_graph(in_item_t it);
    int lim;
    int depth;
    int i;
    int k;
    bit found;
    bit pushed;
    bit seen[VTX_SLOTS];
    logic [VTX_W-1:0] stk_vtx[VTX_SLOTS];
    int stk_pos[VTX_SLOTS];
    logic [VTX_W-1:0] d;
    lim = active_limit();
    case (it.op)
      OP_CLEAR: begin
        edge_fill = 0;
        note_reply(ST_CLEARED, '0, 1'b1);
      end
      OP_ADD: begin
        if (edge_fill >= TABLE_DEPTH || it.from_vertex >= lim || it.to_vertex >= lim) begin
          note_reply(ST_REJECTED, '0, 1'b1);
        end else begin
          edge_from[edge_fill] = it.from_vertex;
          edge_to[edge_fill] = it.to_vertex;
          edge_fill++;
          note_reply(ST_ADDED, '0, 1'b1);
        end
      end
      OP_QUERY: begin
        found = 1'b0;
        depth = 0;
        if (it.from_vertex < lim && it.to_vertex < lim) begin
          foreach (seen[j]) seen[j] = 1'b0;
          seen[it.from_vertex] = 1'b1;
          stk_vtx[0] = it.from_vertex;
          stk_pos[0] = edge_fill;
          depth = 1;
          found = (it.from_vertex == it.to_vertex);
          while (!found && depth > 0) begin
            pushed = 1'b0;
            i = stk_pos[depth-1];
            while (i > 0 && !pushed) begin
              i--;
              if (edge_from[i] == stk_vtx[depth-1] && edge_to[i] < lim && !seen[edge_to[i]]) begin
                stk_pos[depth-1] = i;
                d = edge_to[i];
                seen[d] = 1'b1;
                stk_vtx[depth] = d;
                stk_pos[depth] = edge_fill;
                depth++;
                found = (d == it.to_vertex);
                pushed = 1'b1;
              end
            end
            if (!pushed) depth--;
          end
        end
        if (found) begin
          for (k = depth - 1; k >= 0; k--) note_reply(ST_PATH, stk_vtx[k], k == 0);
        end else begin
          note_reply(ST_NOPATH, '0, 1'b1);
        end
      end
      default: note_reply(ST_REJECTED, '0, 1'b1);
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (graph_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= graph_cmds.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor, predictor update and watchdog
  always @(posedge clk) begin
    out_item_t want;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        moved = 1'b1;
        if (graph_replies.size() == 0) begin
          $error("result with nothing pending: %p", out_data);
          failed = 1'b1;
        end else begin
          want = graph_replies.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            failed = 1'b1;
          end
          if (out_data.vertex !== want.vertex) begin
            $error("vertex: expected %0d, got %0d", want.vertex, out_data.vertex);
            failed = 1'b1;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data.last);
            failed = 1'b1;
          end
        end
      end
      if (in_valid && in_stall === 1'b0) begin
        moved = 1'b1;
        cmds_taken++;
        walk_graph(in_data);
      end
      if (cfg_valid && cfg_ready === 1'b1) begin
        moved = 1'b1;
        vcount_now = cfg_data;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
    in_took <= rst_n && in_valid && in_stall === 1'b0;
    cfg_took <= rst_n && cfg_valid && cfg_ready === 1'b1;
  end

  function automatic void queue_cmd(logic [OP_W-1:0] op, int a, int b);
    in_item_t it;
    it.op = op;
    it.from_vertex = VTX_W'(a);
    it.to_vertex = VTX_W'(b);
    graph_cmds.push_back(it);
    cmds_queued++;
  endfunction

  task automatic drain();
    while (cmds_taken != cmds_queued || graph_replies.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_vertex_count(int v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= VCNT_W'(v);
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick(int base, int span);
    return base + $urandom_range(span - 1, 0);
  endfunction

  // mostly clear/add/query sequences on a small vertex window, some noise
  task automatic random_traffic(int budget);
    int sent;
    int lim;
    int span;
    int base;
    int n;
    logic [OP_W-1:0] op;
    sent = 0;
    lim = active_limit();
    while (sent < budget) begin
      if ($urandom_range(9) < 7) begin
        queue_cmd(OP_CLEAR, $urandom_range(31), $urandom_range(31));
        sent++;
        span = $urandom_range((lim < 10) ? lim : 10, 1);
        base = $urandom_range(lim - span, 0);
        n = $urandom_range(14, 2);
        repeat (n) begin
          if ($urandom_range(9) == 0)
            queue_cmd(OP_ADD, $urandom_range(31), $urandom_range(31));
          else
            queue_cmd(OP_ADD, pick(base, span), pick(base, span));
        end
        sent += n;
        n = $urandom_range(4, 1);
        repeat (n) begin
          if ($urandom_range(7) == 0)
            queue_cmd(OP_QUERY, $urandom_range(31), $urandom_range(31));
          else
            queue_cmd(OP_QUERY, pick(base, span), pick(base, span));
        end
        sent += n;
      end else begin
        op = OP_W'($urandom_range(3));
        queue_cmd(op, $urandom_range(31), $urandom_range(31));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    queue_cmd(OP_QUERY, 0, 0);
    queue_cmd(OP_QUERY, 31, 0);
    queue_cmd(OP_UNUSED, 31, 31);
    queue_cmd(OP_ADD, 0, 31);
    queue_cmd(OP_ADD, 31, 0);
    queue_cmd(OP_ADD, 31, 31);
    queue_cmd(OP_ADD, 0, 5);
    queue_cmd(OP_ADD, 5, 6);
    queue_cmd(OP_ADD, 6, 7);
    queue_cmd(OP_QUERY, 0, 7);
    queue_cmd(OP_QUERY, 31, 7);
    queue_cmd(OP_QUERY, 7, 0);
    queue_cmd(OP_CLEAR, 31, 31);
    queue_cmd(OP_QUERY, 0, 31);
    queue_cmd(OP_ADD, 1, 3);
    queue_cmd(OP_ADD, 3, 2);
    queue_cmd(OP_ADD, 20, 2);
    queue_cmd(OP_ADD, 1, 20);
    drain();

    // lowered limit: edge 1->20 must be skipped
    set_vertex_count(8);
    queue_cmd(OP_QUERY, 1, 2);
    queue_cmd(OP_ADD, 7, 8);
    queue_cmd(OP_ADD, 8, 0);
    queue_cmd(OP_QUERY, 9, 0);
    queue_cmd(OP_QUERY, 0, 8);
    drain();

    set_vertex_count(0);
    queue_cmd(OP_ADD, 0, 0);
    queue_cmd(OP_QUERY, 0, 0);
    drain();

    // 63 caps at 32; longest path, then table full
    set_vertex_count(63);
    queue_cmd(OP_ADD, 31, 31);
    queue_cmd(OP_CLEAR, 0, 0);
    for (int v = 0; v < VTX_SLOTS - 1; v++) queue_cmd(OP_ADD, v, v + 1);
    queue_cmd(OP_QUERY, 0, 31);
    repeat (TABLE_DEPTH - VTX_SLOTS + 1) queue_cmd(OP_ADD, $urandom_range(31), $urandom_range(31));
    queue_cmd(OP_ADD, 2, 3);
    queue_cmd(OP_ADD, $urandom_range(31), $urandom_range(31));
    repeat (3) queue_cmd(OP_QUERY, $urandom_range(31), $urandom_range(31));
    queue_cmd(OP_QUERY, 17, 17);
    drain();

    send_idle_pct = 56;
    set_vertex_count($urandom_range(31, 2));
    random_traffic(30);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 56;
    set_vertex_count(1);
    random_traffic(10);
    drain();
    set_vertex_count(32);
    random_traffic(25);
    drain();

    send_idle_pct = 12;
    recv_stall_pct = 12;
    set_vertex_count($urandom_range(32, 1));
    random_traffic(35);
    drain();
    repeat (40) @(negedge clk);

    if (!failed) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: graph_dfs_path_finder.f
hw/rtl/gdfs_pkg.sv
hw/rtl/gdfs_ctrl.sv
hw/rtl/gdfs_dp.sv
hw/rtl/graph_dfs_path_finder.sv
bench/tb_graph_dfs_path_finder.sv
